// ===== hdl/t16dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t16dec_pkg: shared types and constants of the Thumb 16-bit decoder
// Holds the decoded record, its code enums, register and flag constants, and
// the access size table of the register-offset load/store group.
// ----------------------------------------------------------------------------
package t16dec_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNDEFINED  = 2'd1,
    ST_UNPREDICT  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    CLS_DPREG   = 5'd0,
    CLS_DPSHIFT = 5'd1,
    CLS_DPIMM   = 5'd2,
    CLS_MUL     = 5'd3,
    CLS_BX      = 5'd4,
    CLS_BLX     = 5'd5,
    CLS_LDRLIT  = 5'd6,
    CLS_LDRREG  = 5'd7,
    CLS_STRREG  = 5'd8,
    CLS_LDRIMM  = 5'd9,
    CLS_STRIMM  = 5'd10,
    CLS_CBZ     = 5'd11,
    CLS_EXT     = 5'd12,
    CLS_STM     = 5'd13,
    CLS_LDM     = 5'd14,
    CLS_CPS     = 5'd15,
    CLS_HINT    = 5'd16,
    CLS_IT      = 5'd17,
    CLS_SVC     = 5'd18,
    CLS_B       = 5'd19
  } class_e;

  // Register numbers.
  localparam logic [4:0] REG_SP   = 5'd13;
  localparam logic [4:0] REG_PC   = 5'd15;
  localparam logic [4:0] REG_NONE = 5'd16;

  // Operation codes, some beyond the 4-bit Thumb data processing opcode.
  localparam logic [4:0] OP_CMP  = 5'd10;
  localparam logic [4:0] OP_MOV  = 5'd16;
  localparam logic [4:0] OP_ADD  = 5'd17;
  localparam logic [4:0] OP_SUB  = 5'd18;
  localparam logic [4:0] OP_BKPT = 5'd16;
  localparam logic [4:0] COND_AL = 5'd14;

  // Condition field values that do not encode a conditional branch.
  localparam logic [3:0] COND_UDF = 4'hE;
  localparam logic [3:0] COND_SVC = 4'hF;

  // Thumb data processing opcodes that need special register handling.
  localparam logic [3:0] ALU_TST = 4'd8;
  localparam logic [3:0] ALU_RSB = 4'd9;
  localparam logic [3:0] ALU_CMP = 4'd10;
  localparam logic [3:0] ALU_CMN = 4'd11;
  localparam logic [3:0] ALU_MUL = 4'd13;
  localparam logic [3:0] ALU_MVN = 4'd15;

  // Miscellaneous group opcodes, bits 11:8.
  localparam logic [3:0] MISC_SP_ADJ  = 4'h0;
  localparam logic [3:0] MISC_CB0     = 4'h1;
  localparam logic [3:0] MISC_EXTEND  = 4'h2;
  localparam logic [3:0] MISC_CB1     = 4'h3;
  localparam logic [3:0] MISC_PUSH_LO = 4'h4;
  localparam logic [3:0] MISC_PUSH_HI = 4'h5;
  localparam logic [3:0] MISC_CPS     = 4'h6;
  localparam logic [3:0] MISC_CB2     = 4'h9;
  localparam logic [3:0] MISC_REV     = 4'hA;
  localparam logic [3:0] MISC_CB3     = 4'hB;
  localparam logic [3:0] MISC_POP_LO  = 4'hC;
  localparam logic [3:0] MISC_POP_HI  = 4'hD;
  localparam logic [3:0] MISC_BKPT    = 4'hE;
  localparam logic [3:0] MISC_IT_HINT = 4'hF;

  // High register group operations, bits 9:8.
  localparam logic [1:0] HI_ADD = 2'd0;
  localparam logic [1:0] HI_CMP = 2'd1;
  localparam logic [1:0] HI_MOV = 2'd2;

  // Shift kinds.
  localparam logic [1:0] SHK_LSL = 2'd0;

  // Access sizes.
  localparam logic [1:0] SZ_NONE = 2'd0;
  localparam logic [1:0] SZ_BYTE = 2'd1;
  localparam logic [1:0] SZ_HALF = 2'd2;
  localparam logic [1:0] SZ_WORD = 2'd3;

  // Flag bit masks.
  localparam logic [5:0] FL_NONE = 6'h00;
  localparam logic [5:0] FL_S    = 6'h01;
  localparam logic [5:0] FL_SGN  = 6'h02;
  localparam logic [5:0] FL_ADD  = 6'h04;
  localparam logic [5:0] FL_PRE  = 6'h08;
  localparam logic [5:0] FL_WB   = 6'h10;
  localparam logic [5:0] FL_LNK  = 6'h20;

  localparam logic [5:0] SHIFT_32 = 6'd32;

  typedef struct packed {
    status_e            status;
    class_e             insn_class;
    logic [4:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         base_reg;
    logic [4:0]         second_reg;
    logic signed [11:0] immediate;
    logic [15:0]        reg_mask;
    logic [1:0]         shift_kind;
    logic [5:0]         shift_dist;
    logic [1:0]         xfer_size;
    logic [5:0]         flag_bits;
  } dec_rec_t;

  // Record with every field at its unused value.
  function automatic dec_rec_t blank_rec(status_e st);
    dec_rec_t r;
    r.status     = st;
    r.insn_class = CLS_DPREG;
    r.operation  = '0;
    r.dest_reg   = REG_NONE;
    r.base_reg   = REG_NONE;
    r.second_reg = REG_NONE;
    r.immediate  = '0;
    r.reg_mask   = '0;
    r.shift_kind = SHK_LSL;
    r.shift_dist = '0;
    r.xfer_size  = SZ_NONE;
    r.flag_bits  = FL_NONE;
    return r;
  endfunction

  // Access size of the register-offset group, selected by opcode bits 11:9.
  function automatic logic [1:0] regofs_size(logic [2:0] opc);
    logic [1:0] sz;
    case (opc)
      3'd0:    sz = SZ_WORD;
      3'd1:    sz = SZ_HALF;
      3'd2:    sz = SZ_BYTE;
      3'd3:    sz = SZ_BYTE;
      3'd4:    sz = SZ_WORD;
      3'd5:    sz = SZ_HALF;
      3'd6:    sz = SZ_BYTE;
      default: sz = SZ_HALF;
    endcase
    return sz;
  endfunction

endpackage

// ===== hdl/t16dec_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t16dec_decode: decode logic of one 16-bit Thumb instruction word
// Splits the word on bits 15:11 and fills the decoded record.
// ----------------------------------------------------------------------------
module t16dec_decode (
  input  logic [15:0]           insn_i,
  output t16dec_pkg::dec_rec_t  rec_o
);
  import t16dec_pkg::*;

  logic [4:0] top;
  logic [4:0] imm5;
  logic [3:0] alu_op;
  logic [3:0] misc_op;
  logic [2:0] ls_opc;
  logic [7:0] list8;
  logic [2:0] mrn;
  dec_rec_t   r;
  logic       fail_undef;
  logic       fail_unpred;

  assign top     = insn_i[15:11];
  assign imm5    = insn_i[10:6];
  assign alu_op  = insn_i[9:6];
  assign misc_op = insn_i[11:8];
  assign ls_opc  = insn_i[11:9];
  assign list8   = insn_i[7:0];
  assign mrn     = insn_i[10:8];

  always_comb begin
    r           = blank_rec(ST_OK);
    fail_undef  = 1'b0;
    fail_unpred = 1'b0;

    if (top inside {[5'd0:5'd7]}) begin
      r.flag_bits = FL_S;
      if (top inside {[5'd0:5'd2]}) begin
        // Shift by immediate; LSL #0 is a plain register move.
        r.operation  = OP_MOV;
        r.dest_reg   = {2'b00, insn_i[2:0]};
        r.second_reg = {2'b00, insn_i[5:3]};
        if (top == 5'd0 && imm5 == 5'd0) begin
          r.insn_class = CLS_DPREG;
        end else begin
          r.insn_class = CLS_DPSHIFT;
          r.shift_kind = top[1:0];
          r.shift_dist = (imm5 == 5'd0) ? SHIFT_32 : {1'b0, imm5};
        end
      end else if (top == 5'd3) begin
        r.dest_reg  = {2'b00, insn_i[2:0]};
        r.base_reg  = {2'b00, insn_i[5:3]};
        r.operation = insn_i[9] ? OP_SUB : OP_ADD;
        if (insn_i[10]) begin
          r.insn_class = CLS_DPIMM;
          r.immediate  = {9'd0, insn_i[8:6]};
        end else begin
          r.insn_class = CLS_DPREG;
          r.second_reg = {2'b00, insn_i[8:6]};
        end
      end else begin
        r.insn_class = CLS_DPIMM;
        r.immediate  = {4'd0, insn_i[7:0]};
        r.dest_reg   = {2'b00, insn_i[10:8]};
        case (top[1:0])
          2'd0: begin
            r.operation = OP_MOV;
          end
          2'd1: begin
            r.operation = OP_CMP;
            r.base_reg  = {2'b00, insn_i[10:8]};
            r.dest_reg  = REG_NONE;
          end
          2'd2: begin
            r.operation = OP_ADD;
            r.base_reg  = {2'b00, insn_i[10:8]};
          end
          default: begin
            r.operation = OP_SUB;
            r.base_reg  = {2'b00, insn_i[10:8]};
          end
        endcase
      end
    end else if (top == 5'd8) begin
      if (insn_i[10]) begin
        // High register operations and branch exchange.
        r.second_reg = {1'b0, insn_i[6:3]};
        case (insn_i[9:8])
          HI_ADD: begin
            r.operation = OP_ADD;
            r.dest_reg  = {1'b0, insn_i[7], insn_i[2:0]};
            r.base_reg  = {1'b0, insn_i[7], insn_i[2:0]};
          end
          HI_CMP: begin
            r.operation = OP_CMP;
            r.base_reg  = {1'b0, insn_i[7], insn_i[2:0]};
            r.flag_bits = FL_S;
          end
          HI_MOV: begin
            r.operation = OP_MOV;
            r.dest_reg  = {1'b0, insn_i[7], insn_i[2:0]};
          end
          default: begin
            if (insn_i[7]) begin
              r.insn_class = CLS_BLX;
              r.flag_bits  = FL_LNK;
            end else begin
              r.insn_class = CLS_BX;
            end
          end
        endcase
      end else begin
        // Two-register data processing.
        r.insn_class = CLS_DPREG;
        r.operation  = {1'b0, alu_op};
        r.dest_reg   = {2'b00, insn_i[2:0]};
        r.base_reg   = {2'b00, insn_i[2:0]};
        r.second_reg = {2'b00, insn_i[5:3]};
        r.flag_bits  = FL_S;
        if (alu_op inside {ALU_TST, ALU_CMP, ALU_CMN}) begin
          r.dest_reg = REG_NONE;
        end else if (alu_op == ALU_RSB) begin
          r.insn_class = CLS_DPIMM;
          r.base_reg   = {2'b00, insn_i[5:3]};
        end else if (alu_op == ALU_MUL) begin
          r.insn_class = CLS_MUL;
          r.operation  = '0;
        end else if (alu_op == ALU_MVN) begin
          r.base_reg = REG_NONE;
        end
      end
    end else if (top == 5'd9) begin
      r.insn_class = CLS_LDRLIT;
      r.dest_reg   = {2'b00, insn_i[10:8]};
      r.base_reg   = REG_PC;
      r.immediate  = {2'd0, insn_i[7:0], 2'b00};
      r.xfer_size  = SZ_WORD;
      r.flag_bits  = FL_ADD;
    end else if (top inside {[5'd10:5'd11]}) begin
      r.dest_reg   = {2'b00, insn_i[2:0]};
      r.base_reg   = {2'b00, insn_i[5:3]};
      r.second_reg = {2'b00, insn_i[8:6]};
      r.insn_class = (ls_opc >= 3'd3) ? CLS_LDRREG : CLS_STRREG;
      r.xfer_size  = regofs_size(ls_opc);
      r.flag_bits  = FL_ADD | ((ls_opc == 3'd3 || ls_opc == 3'd7) ? FL_SGN : FL_NONE);
    end else if (top inside {[5'd12:5'd19]}) begin
      r.insn_class = insn_i[11] ? CLS_LDRIMM : CLS_STRIMM;
      r.flag_bits  = FL_ADD | FL_PRE;
      if (top inside {[5'd18:5'd19]}) begin
        r.dest_reg  = {2'b00, insn_i[10:8]};
        r.base_reg  = REG_SP;
        r.immediate = {2'd0, insn_i[7:0], 2'b00};
        r.xfer_size = SZ_WORD;
      end else begin
        r.dest_reg = {2'b00, insn_i[2:0]};
        r.base_reg = {2'b00, insn_i[5:3]};
        if (top inside {[5'd12:5'd13]}) begin
          r.immediate = {5'd0, imm5, 2'b00};
          r.xfer_size = SZ_WORD;
        end else if (top inside {[5'd14:5'd15]}) begin
          r.immediate = {7'd0, imm5};
          r.xfer_size = SZ_BYTE;
        end else begin
          r.immediate = {6'd0, imm5, 1'b0};
          r.xfer_size = SZ_HALF;
        end
      end
    end else if (top inside {[5'd20:5'd21]}) begin
      r.insn_class = CLS_DPIMM;
      r.operation  = OP_ADD;
      r.dest_reg   = {2'b00, insn_i[10:8]};
      r.base_reg   = (top == 5'd20) ? REG_PC : REG_SP;
      r.immediate  = {2'd0, insn_i[7:0], 2'b00};
    end else if (top inside {[5'd22:5'd23]}) begin
      // Miscellaneous group, selected by bits 11:8.
      case (misc_op)
        MISC_SP_ADJ: begin
          r.insn_class = CLS_DPIMM;
          r.operation  = insn_i[7] ? OP_SUB : OP_ADD;
          r.dest_reg   = REG_SP;
          r.base_reg   = REG_SP;
          r.immediate  = {3'd0, insn_i[6:0], 2'b00};
        end
        MISC_CB0, MISC_CB1, MISC_CB2, MISC_CB3: begin
          r.insn_class = CLS_CBZ;
          r.base_reg   = {2'b00, insn_i[2:0]};
          r.immediate  = {5'd0, insn_i[9], insn_i[7:3], 1'b0};
          r.operation  = {4'd0, insn_i[11]};
        end
        MISC_EXTEND: begin
          r.insn_class = CLS_EXT;
          r.dest_reg   = {2'b00, insn_i[2:0]};
          r.second_reg = {2'b00, insn_i[5:3]};
          r.flag_bits  = insn_i[7] ? FL_NONE : FL_SGN;
          r.xfer_size  = insn_i[6] ? SZ_BYTE : SZ_HALF;
        end
        MISC_PUSH_LO, MISC_PUSH_HI: begin
          r.insn_class = CLS_STM;
          r.base_reg   = REG_SP;
          r.reg_mask   = {1'b0, insn_i[8], 6'd0, insn_i[7:0]};
          r.flag_bits  = FL_WB;
        end
        MISC_CPS: begin
          r.insn_class = CLS_CPS;
          r.immediate  = {7'd0, insn_i[4:0]};
        end
        MISC_REV: begin
          r.insn_class = CLS_EXT;
          r.dest_reg   = {2'b00, insn_i[2:0]};
          r.second_reg = {2'b00, insn_i[5:3]};
          r.operation  = {3'd0, insn_i[7:6]};
        end
        MISC_POP_LO, MISC_POP_HI: begin
          r.insn_class = CLS_LDM;
          r.base_reg   = REG_SP;
          r.reg_mask   = {insn_i[8], 7'd0, insn_i[7:0]};
          r.flag_bits  = FL_WB | FL_ADD;
        end
        MISC_BKPT: begin
          r.insn_class = CLS_HINT;
          r.operation  = OP_BKPT;
          r.immediate  = {4'd0, insn_i[7:0]};
        end
        MISC_IT_HINT: begin
          r.operation = {1'b0, insn_i[7:4]};
          if (insn_i[3:0] != 4'd0) begin
            r.insn_class = CLS_IT;
            r.immediate  = {8'd0, insn_i[3:0]};
          end else begin
            r.insn_class = CLS_HINT;
          end
        end
        default: begin
          fail_undef = 1'b1;
        end
      endcase
    end else if (top inside {[5'd24:5'd25]}) begin
      if (list8 == 8'd0) begin
        fail_unpred = 1'b1;
      end else begin
        r.base_reg = {2'b00, mrn};
        r.reg_mask = {8'd0, list8};
        if (top[0]) begin
          // Writeback only when the base is not reloaded from the list.
          r.insn_class = CLS_LDM;
          r.flag_bits  = FL_ADD | (list8[mrn] ? FL_NONE : FL_WB);
        end else begin
          r.insn_class = CLS_STM;
          r.flag_bits  = FL_ADD | FL_WB;
        end
      end
    end else if (top inside {[5'd26:5'd27]}) begin
      if (insn_i[11:8] == COND_UDF) begin
        fail_undef = 1'b1;
      end else if (insn_i[11:8] == COND_SVC) begin
        r.insn_class = CLS_SVC;
        r.immediate  = {4'd0, insn_i[7:0]};
      end else begin
        r.insn_class = CLS_B;
        r.operation  = {1'b0, insn_i[11:8]};
        r.immediate  = {{3{insn_i[7]}}, insn_i[7:0], 1'b0};
      end
    end else if (top == 5'd28) begin
      r.insn_class = CLS_B;
      r.operation  = COND_AL;
      r.immediate  = {insn_i[10:0], 1'b0};
    end else begin
      // First halfword of a 32-bit encoding.
      fail_undef = 1'b1;
    end

    if (fail_undef) begin
      r = blank_rec(ST_UNDEFINED);
    end else if (fail_unpred) begin
      r = blank_rec(ST_UNPREDICT);
    end
  end

  assign rec_o = r;

endmodule

// ===== hdl/thumb16_instruction_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb16_instruction_decoder: 16-bit Thumb instruction decoder
// Registered decoder that turns one Thumb instruction word into a decoded
// record per transaction.
// ----------------------------------------------------------------------------
// The decoder takes one 16-bit instruction per clock cycle while the output
// side does not stall and returns one decoded record for each, in order,
// through the input and result registers. The word is captured in an
// input register, decoded by a single shallow logic cone that splits it on
// bits 15:11, and the record is held in a result register until the
// downstream side takes it. Both registers hold a transaction of their own,
// so a new instruction is still taken while a finished record waits; the
// input stalls only when both registers are full and the output is stalled.
// Encodings that start a 32-bit instruction, the permanently undefined
// conditional branch and unassigned miscellaneous opcodes report status
// undefined; an empty load or store multiple list reports unpredictable.
// In both cases every other field holds its unused value.
// ----------------------------------------------------------------------------
module thumb16_instruction_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Instruction channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        instruction_i,
  // Decoded record channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [4:0]         insn_class_o,
  output logic [4:0]         operation_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         base_reg_o,
  output logic [4:0]         second_reg_o,
  output logic signed [11:0] immediate_o,
  output logic [15:0]        reg_mask_o,
  output logic [1:0]         shift_kind_o,
  output logic [5:0]         shift_dist_o,
  output logic [1:0]         xfer_size_o,
  output logic [5:0]         flag_bits_o
);
  import t16dec_pkg::*;

  // Input register stage.
  logic        in_valid_q;
  logic        in_valid_d;
  logic [15:0] insn_q;
  logic        in_load;

  // Result register stage.
  logic        out_valid_q;
  logic        out_valid_d;
  dec_rec_t    rec_q;
  dec_rec_t    rec_d;
  logic        out_load;

  // The result register can take a new record when it is empty or its
  // record leaves in this cycle; the input register likewise.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_load    = !in_valid_q || out_load;
  assign in_stall_o = !in_load;

  assign in_valid_d  = in_load ? in_valid_i : in_valid_q;
  assign out_valid_d = out_load ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only with a transaction and carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      insn_q <= instruction_i;
    end
    if (out_load && in_valid_q) begin
      rec_q <= rec_d;
    end
  end

  t16dec_decode u_decode (
    .insn_i (insn_q),
    .rec_o  (rec_d)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = rec_q.status;
  assign insn_class_o = rec_q.insn_class;
  assign operation_o  = rec_q.operation;
  assign dest_reg_o   = rec_q.dest_reg;
  assign base_reg_o   = rec_q.base_reg;
  assign second_reg_o = rec_q.second_reg;
  assign immediate_o  = rec_q.immediate;
  assign reg_mask_o   = rec_q.reg_mask;
  assign shift_kind_o = rec_q.shift_kind;
  assign shift_dist_o = rec_q.shift_dist;
  assign xfer_size_o  = rec_q.xfer_size;
  assign flag_bits_o  = rec_q.flag_bits;

  // The input only stalls when both stages hold a transaction.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled while a stage was free");

  // A held instruction moves into the result register when it can.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_load) |=> out_valid_o)
    else $error("decoded instruction was dropped");

  // Prefixes of 32-bit encodings must come out as undefined.
  a_prefix_undef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_load && insn_q[15:13] == 3'b111 && insn_q[12:11] != 2'b00)
    |=> (status_o == ST_UNDEFINED && dest_reg_o == REG_NONE))
    else $error("32-bit prefix not reported as undefined");

  // A shift amount only appears on the shifted data processing class.
  a_shift_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shift_dist_o != 6'd0) |-> (insn_class_o == CLS_DPSHIFT))
    else $error("shift amount outside shifted form");

endmodule

// ===== verif/t16dec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t16dec_checker: decoded record predictor and scoreboard
// Watches both channels of the Thumb 16-bit decoder, predicts the record of
// every instruction taken and compares each record handed out against it.
// ----------------------------------------------------------------------------
module t16dec_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [15:0]        instruction_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [4:0]         insn_class_i,
  input  logic [4:0]         operation_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [4:0]         base_reg_i,
  input  logic [4:0]         second_reg_i,
  input  logic signed [11:0] immediate_i,
  input  logic [15:0]        reg_mask_i,
  input  logic [1:0]         shift_kind_i,
  input  logic [5:0]         shift_dist_i,
  input  logic [1:0]         xfer_size_i,
  input  logic [5:0]         flag_bits_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import t16dec_pkg::*;

  dec_rec_t pending_records[$];

  function automatic dec_rec_t decode_word(logic [15:0] w);
    dec_rec_t r;
    dec_rec_t idle;
    status_e  bad;
    logic [4:0] top;
    logic [4:0] imm5;
    logic [2:0] opc;
    logic [3:0] misc;
    logic [2:0] rn3;
    r.status     = ST_OK;
    r.insn_class = CLS_DPREG;
    r.operation  = 5'd0;
    r.dest_reg   = REG_NONE;
    r.base_reg   = REG_NONE;
    r.second_reg = REG_NONE;
    r.immediate  = 12'sd0;
    r.reg_mask   = 16'd0;
    r.shift_kind = 2'd0;
    r.shift_dist = 6'd0;
    r.xfer_size  = SZ_NONE;
    r.flag_bits  = FL_NONE;
    idle = r;
    bad  = ST_OK;
    top  = w[15:11];
    imm5 = w[10:6];
    opc  = w[11:9];
    misc = w[11:8];
    rn3  = w[10:8];
    if (top <= 5'd2) begin
      // Shift by immediate; LSL #0 is a plain register move.
      r.flag_bits  = FL_S;
      r.operation  = OP_MOV;
      r.dest_reg   = {2'b0, w[2:0]};
      r.second_reg = {2'b0, w[5:3]};
      if (top == 5'd0 && imm5 == 5'd0) begin
        r.insn_class = CLS_DPREG;
      end else begin
        r.insn_class = CLS_DPSHIFT;
        r.shift_kind = top[1:0];
        r.shift_dist = (imm5 == 5'd0) ? SHIFT_32 : {1'b0, imm5};
      end
    end else if (top == 5'd3) begin
      r.flag_bits = FL_S;
      r.dest_reg  = {2'b0, w[2:0]};
      r.base_reg  = {2'b0, w[5:3]};
      r.operation = w[9] ? OP_SUB : OP_ADD;
      if (w[10]) begin
        r.insn_class = CLS_DPIMM;
        r.immediate  = {9'b0, w[8:6]};
      end else begin
        r.insn_class = CLS_DPREG;
        r.second_reg = {2'b0, w[8:6]};
      end
    end else if (top <= 5'd7) begin
      r.flag_bits  = FL_S;
      r.insn_class = CLS_DPIMM;
      r.immediate  = {4'b0, w[7:0]};
      r.dest_reg   = {2'b0, rn3};
      if (top == 5'd4) begin
        r.operation = OP_MOV;
      end else if (top == 5'd5) begin
        r.operation = OP_CMP;
        r.base_reg  = {2'b0, rn3};
        r.dest_reg  = REG_NONE;
      end else begin
        r.operation = (top == 5'd6) ? OP_ADD : OP_SUB;
        r.base_reg  = {2'b0, rn3};
      end
    end else if (top == 5'd8 && !w[10]) begin
      r.insn_class = CLS_DPREG;
      r.operation  = {1'b0, w[9:6]};
      r.dest_reg   = {2'b0, w[2:0]};
      r.base_reg   = {2'b0, w[2:0]};
      r.second_reg = {2'b0, w[5:3]};
      r.flag_bits  = FL_S;
      case (w[9:6])
        ALU_TST, ALU_CMP, ALU_CMN: r.dest_reg = REG_NONE;
        ALU_RSB: begin
          r.insn_class = CLS_DPIMM;
          r.base_reg   = {2'b0, w[5:3]};
        end
        ALU_MUL: begin
          r.insn_class = CLS_MUL;
          r.operation  = 5'd0;
        end
        ALU_MVN: r.base_reg = REG_NONE;
        default: ;
      endcase
    end else if (top == 5'd8) begin
      r.second_reg = {1'b0, w[6:3]};
      case (w[9:8])
        HI_ADD: begin
          r.operation = OP_ADD;
          r.dest_reg  = {1'b0, w[7], w[2:0]};
          r.base_reg  = {1'b0, w[7], w[2:0]};
        end
        HI_CMP: begin
          r.operation = OP_CMP;
          r.base_reg  = {1'b0, w[7], w[2:0]};
          r.flag_bits = FL_S;
        end
        HI_MOV: begin
          r.operation = OP_MOV;
          r.dest_reg  = {1'b0, w[7], w[2:0]};
        end
        default: begin
          if (w[7]) begin
            r.insn_class = CLS_BLX;
            r.flag_bits  = FL_LNK;
          end else begin
            r.insn_class = CLS_BX;
          end
        end
      endcase
    end else if (top == 5'd9) begin
      r.insn_class = CLS_LDRLIT;
      r.dest_reg   = {2'b0, rn3};
      r.base_reg   = REG_PC;
      r.immediate  = {2'b0, w[7:0], 2'b00};
      r.xfer_size  = SZ_WORD;
      r.flag_bits  = FL_ADD;
    end else if (top <= 5'd11) begin
      r.dest_reg   = {2'b0, w[2:0]};
      r.base_reg   = {2'b0, w[5:3]};
      r.second_reg = {2'b0, w[8:6]};
      r.insn_class = (opc >= 3'd3) ? CLS_LDRREG : CLS_STRREG;
      case (opc)
        3'd0, 3'd4:       r.xfer_size = SZ_WORD;
        3'd1, 3'd5, 3'd7: r.xfer_size = SZ_HALF;
        default:          r.xfer_size = SZ_BYTE;
      endcase
      r.flag_bits = (opc == 3'd3 || opc == 3'd7) ? (FL_ADD | FL_SGN) : FL_ADD;
    end else if (top <= 5'd19) begin
      r.insn_class = w[11] ? CLS_LDRIMM : CLS_STRIMM;
      r.flag_bits  = FL_ADD | FL_PRE;
      if (top >= 5'd18) begin
        r.dest_reg  = {2'b0, rn3};
        r.base_reg  = REG_SP;
        r.immediate = {2'b0, w[7:0], 2'b00};
        r.xfer_size = SZ_WORD;
      end else begin
        r.dest_reg = {2'b0, w[2:0]};
        r.base_reg = {2'b0, w[5:3]};
        if (top <= 5'd13) begin
          r.immediate = {5'b0, imm5, 2'b00};
          r.xfer_size = SZ_WORD;
        end else if (top <= 5'd15) begin
          r.immediate = {7'b0, imm5};
          r.xfer_size = SZ_BYTE;
        end else begin
          r.immediate = {6'b0, imm5, 1'b0};
          r.xfer_size = SZ_HALF;
        end
      end
    end else if (top <= 5'd21) begin
      r.insn_class = CLS_DPIMM;
      r.operation  = OP_ADD;
      r.dest_reg   = {2'b0, rn3};
      r.base_reg   = (top == 5'd20) ? REG_PC : REG_SP;
      r.immediate  = {2'b0, w[7:0], 2'b00};
    end else if (top <= 5'd23) begin
      case (misc)
        MISC_SP_ADJ: begin
          r.insn_class = CLS_DPIMM;
          r.operation  = w[7] ? OP_SUB : OP_ADD;
          r.dest_reg   = REG_SP;
          r.base_reg   = REG_SP;
          r.immediate  = {3'b0, w[6:0], 2'b00};
        end
        MISC_CB0, MISC_CB1, MISC_CB2, MISC_CB3: begin
          r.insn_class = CLS_CBZ;
          r.base_reg   = {2'b0, w[2:0]};
          r.immediate  = {5'b0, w[9], w[7:3], 1'b0};
          r.operation  = {4'b0, w[11]};
        end
        MISC_EXTEND: begin
          r.insn_class = CLS_EXT;
          r.dest_reg   = {2'b0, w[2:0]};
          r.second_reg = {2'b0, w[5:3]};
          r.flag_bits  = w[7] ? FL_NONE : FL_SGN;
          r.xfer_size  = w[6] ? SZ_BYTE : SZ_HALF;
        end
        MISC_PUSH_LO, MISC_PUSH_HI: begin
          r.insn_class = CLS_STM;
          r.base_reg   = REG_SP;
          r.reg_mask   = {1'b0, w[8], 6'b0, w[7:0]};
          r.flag_bits  = FL_WB;
        end
        MISC_CPS: begin
          r.insn_class = CLS_CPS;
          r.immediate  = {7'b0, w[4:0]};
        end
        MISC_REV: begin
          r.insn_class = CLS_EXT;
          r.dest_reg   = {2'b0, w[2:0]};
          r.second_reg = {2'b0, w[5:3]};
          r.operation  = {3'b0, w[7:6]};
        end
        MISC_POP_LO, MISC_POP_HI: begin
          r.insn_class = CLS_LDM;
          r.base_reg   = REG_SP;
          r.reg_mask   = {w[8], 7'b0, w[7:0]};
          r.flag_bits  = FL_WB | FL_ADD;
        end
        MISC_BKPT: begin
          r.insn_class = CLS_HINT;
          r.operation  = OP_BKPT;
          r.immediate  = {4'b0, w[7:0]};
        end
        MISC_IT_HINT: begin
          // A zero mask turns IT into a hint.
          r.operation = {1'b0, w[7:4]};
          if (w[3:0] != 4'd0) begin
            r.insn_class = CLS_IT;
            r.immediate  = {8'b0, w[3:0]};
          end else begin
            r.insn_class = CLS_HINT;
          end
        end
        default: bad = ST_UNDEFINED;
      endcase
    end else if (top <= 5'd25) begin
      if (w[7:0] == 8'd0) begin
        bad = ST_UNPREDICT;
      end else begin
        r.base_reg = {2'b0, rn3};
        r.reg_mask = {8'b0, w[7:0]};
        if (top == 5'd25) begin
          r.insn_class = CLS_LDM;
          r.flag_bits  = w[rn3] ? FL_ADD : (FL_ADD | FL_WB);
        end else begin
          r.insn_class = CLS_STM;
          r.flag_bits  = FL_ADD | FL_WB;
        end
      end
    end else if (top <= 5'd27) begin
      if (misc == COND_UDF) begin
        bad = ST_UNDEFINED;
      end else if (misc == COND_SVC) begin
        r.insn_class = CLS_SVC;
        r.immediate  = {4'b0, w[7:0]};
      end else begin
        r.insn_class = CLS_B;
        r.operation  = {1'b0, misc};
        r.immediate  = {{3{w[7]}}, w[7:0], 1'b0};
      end
    end else if (top == 5'd28) begin
      r.insn_class = CLS_B;
      r.operation  = COND_AL;
      r.immediate  = {w[10:0], 1'b0};
    end else begin
      bad = ST_UNDEFINED;
    end
    if (bad != ST_OK) begin
      r = idle;
      r.status = bad;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dec_rec_t e;
    if (!rst_ni) begin
      pending_records.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_records.size() == 0) begin
          $display("%0t: record handed out with none expected", $time);
          fail_count_o++;
        end else begin
          e = pending_records.pop_front();
          check_field("status", e.status, status_i);
          check_field("insn_class", e.insn_class, insn_class_i);
          check_field("operation", e.operation, operation_i);
          check_field("dest_reg", e.dest_reg, dest_reg_i);
          check_field("base_reg", e.base_reg, base_reg_i);
          check_field("second_reg", e.second_reg, second_reg_i);
          check_field("immediate", e.immediate, immediate_i);
          check_field("reg_mask", e.reg_mask, reg_mask_i);
          check_field("shift_kind", e.shift_kind, shift_kind_i);
          check_field("shift_dist", e.shift_dist, shift_dist_i);
          check_field("xfer_size", e.xfer_size, xfer_size_i);
          check_field("flag_bits", e.flag_bits, flag_bits_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_records.push_back(decode_word(instruction_i));
      end
      pending_o <= pending_records.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the Thumb 16-bit decoder testbench
// Drives directed and random instruction words through the decoder with
// random idling on both channels, while a checker beside the block predicts
// and compares every decoded record. Reports the verdict at the end.
// ----------------------------------------------------------------------------
module tb;
  import t16dec_pkg::*;

  // Cycles without any transaction on either channel before the run is
  // declared hung. Far beyond the longest stall streak the idling allows.
  localparam int STUCK_LIMIT  = 2000;
  // Random instruction words and the points where the idling pattern changes.
  localparam int RANDOM_WORDS = 500;
  localparam int PHASE2_AT    = 167;
  localparam int PHASE3_AT    = 334;
  // Cycles to keep watching after the last record.
  localparam int TAIL_CYCLES  = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [15:0]        instruction_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [4:0]         insn_class_o;
  logic [4:0]         operation_o;
  logic [4:0]         dest_reg_o;
  logic [4:0]         base_reg_o;
  logic [4:0]         second_reg_o;
  logic signed [11:0] immediate_o;
  logic [15:0]        reg_mask_o;
  logic [1:0]         shift_kind_o;
  logic [5:0]         shift_dist_o;
  logic [1:0]         xfer_size_o;
  logic [5:0]         flag_bits_o;

  int fail_count;
  int pending;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls. They are swapped for the second phase and zeroed for the third.
  int send_idle_pct = 37;
  int recv_idle_pct = 46;

  thumb16_instruction_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .instruction_i (instruction_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .insn_class_o  (insn_class_o),
    .operation_o   (operation_o),
    .dest_reg_o    (dest_reg_o),
    .base_reg_o    (base_reg_o),
    .second_reg_o  (second_reg_o),
    .immediate_o   (immediate_o),
    .reg_mask_o    (reg_mask_o),
    .shift_kind_o  (shift_kind_o),
    .shift_dist_o  (shift_dist_o),
    .xfer_size_o   (xfer_size_o),
    .flag_bits_o   (flag_bits_o)
  );

  t16dec_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .instruction_i (instruction_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .insn_class_i  (insn_class_o),
    .operation_i   (operation_o),
    .dest_reg_i    (dest_reg_o),
    .base_reg_i    (base_reg_o),
    .second_reg_i  (second_reg_o),
    .immediate_i   (immediate_o),
    .reg_mask_i    (reg_mask_o),
    .shift_kind_i  (shift_kind_o),
    .shift_dist_i  (shift_dist_o),
    .xfer_size_i   (xfer_size_o),
    .flag_bits_i   (flag_bits_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // The receiver decides at every falling edge whether to stall the next
  // rising edge. Stall never looks at valid, so gaps fall on every phase.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_idle_pct);
  end

  // Hands one instruction word to the decoder. A random number of idle
  // cycles may come first; once valid is raised, the word is held until the
  // transaction completes at a rising edge with stall low. Valid stays high
  // into the next call, so back-to-back transactions need no gap.
  task automatic send_word(input logic [15:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i    = 1'b0;
      instruction_i = 16'($urandom);
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    instruction_i = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Random word that favors the dense corners of the encoding space: the
  // miscellaneous, multiple transfer and conditional branch groups, and the
  // register data processing group. Half of the words are fully random.
  function automatic logic [15:0] random_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(3))
      2: w[15:11] = 5'(5'd22 + $urandom_range(5));
      3: w[15:11] = 5'd8;
      default: ;
    endcase
    return w;
  endfunction

  // Watchdog: ends the run when no transaction has happened on either
  // channel for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [15:0] directed[$];
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    instruction_i = 16'd0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: many instruction classes, the field extremes, LSL #0 as
    // a plain move, LSR and ASR by 32, MULS, BKPT, IT against a hint with a
    // zero mask, the empty store multiple list, load multiple with and
    // without the base in the list, the permanently undefined branch
    // condition, and the 32-bit prefixes.
    directed = '{16'h0000, 16'h0801, 16'h1000, 16'h17FF, 16'h1A3F, 16'h1FFF,
                 16'h2AFF, 16'h4240, 16'h4340, 16'h43FF, 16'h45FF, 16'h47F8,
                 16'h4FFF, 16'h5E00, 16'h9FFF, 16'hB0FF, 16'hBBFF, 16'hB5FF,
                 16'hB800, 16'hBDFF, 16'hBEFF, 16'hBF18, 16'hBF30, 16'hC000,
                 16'hC9FE, 16'hCA01, 16'hD7FF, 16'hDE00, 16'hDFFF, 16'hE7FF,
                 16'hE800, 16'hFFFF};
    foreach (directed[i]) send_word(directed[i]);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == PHASE2_AT) begin
        send_idle_pct = 46;
        recv_idle_pct = 37;
      end else if (n == PHASE3_AT) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_word(random_word());
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // Drain every expected record, then keep watching for strays.
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== thumb16_instruction_decoder.f =====
hdl/t16dec_pkg.sv
hdl/t16dec_decode.sv
hdl/thumb16_instruction_decoder.sv
verif/t16dec_checker.sv
verif/tb.sv
